/* sv/scope_frame_crc16_encoder_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the scope frame encoder modules
// ----------------------------------------------------------------------------
`ifndef SCOPE_FRAME_CRC16_ENCODER_CORE_ASSERT_SVH
`define SCOPE_FRAME_CRC16_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is held
`define SFCRC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held
`define SFCRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sfcrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcrc_pkg
// Types, constants and the CRC-16/MODBUS byte update for the scope frame
// encoder.
// ----------------------------------------------------------------------------
package sfcrc_pkg;

    localparam int INPUT_FIELDS          = 4;
    localparam int CHANNEL_COUNT_DEFAULT = 4;
    localparam int SAMPLE_BYTES          = 2 * INPUT_FIELDS;

    localparam logic [15:0] CRC_PRESET         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;

    typedef logic [SAMPLE_BYTES-1:0][7:0] bytes_t;

    typedef struct packed {
        logic signed [15:0] channel_3;
        logic signed [15:0] channel_2;
        logic signed [15:0] channel_1;
        logic signed [15:0] channel_0;
    } in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } out_t;

    // One pipeline slot: the sample bytes in transmit order plus running CRC
    typedef struct packed {
        bytes_t      bytes;
        logic [15:0] crc;
    } work_t;

    function automatic bytes_t to_bytes(input in_t item);
        bytes_t b;
        b[0] = item.channel_0[7:0];
        b[1] = item.channel_0[15:8];
        b[2] = item.channel_1[7:0];
        b[3] = item.channel_1[15:8];
        b[4] = item.channel_2[7:0];
        b[5] = item.channel_2[15:8];
        b[6] = item.channel_3[7:0];
        b[7] = item.channel_3[15:8];
        return b;
    endfunction

    // LSB-first CRC update over one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* sv/sfcrc_byte_stage.sv */
`timescale 1ns / 1ps
`include "scope_frame_crc16_encoder_core_assert.svh"
// ----------------------------------------------------------------------------
// sfcrc_byte_stage
// One pipeline stage: folds one sample byte into the running CRC and
// registers the slot, with valid/ready flow control.
// ----------------------------------------------------------------------------
module sfcrc_byte_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfcrc_pkg::work_t in_data,
    input  logic [7:0]       in_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output sfcrc_pkg::work_t out_data
);
    import sfcrc_pkg::*;

    logic  valid_reg;
    work_t data_reg;
    work_t data_next;
    logic  load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next       = in_data;
        data_next.crc   = crc_feed(in_data.crc, in_byte);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    `SFCRC_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, load, valid_reg, "stage lost a request")
    `SFCRC_ASSERT_NEXT(a_stall_holds, aclk, aresetn, valid_reg && !out_ready, valid_reg && $stable(data_reg), "stage changed while stalled")
    `SFCRC_ASSERT_NEXT(a_crc_step, aclk, aresetn, load, data_reg.crc == crc_feed($past(in_data.crc), $past(in_byte)), "stage CRC update wrong")

endmodule

/* sv/sfcrc_serializer.sv */
`timescale 1ns / 1ps
`include "scope_frame_crc16_encoder_core_assert.svh"
// ----------------------------------------------------------------------------
// sfcrc_serializer
// Holds one finished frame and sends it a byte per cycle while m_ready is high: sample bytes,
// then CRC low and high byte, the last one flagged.
// ----------------------------------------------------------------------------
module sfcrc_serializer #(
    parameter int CHANNEL_COUNT = sfcrc_pkg::CHANNEL_COUNT_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfcrc_pkg::work_t in_data,
    output logic             m_valid,
    input  logic             m_ready,
    output sfcrc_pkg::out_t  m_item
);
    import sfcrc_pkg::*;

    localparam int NBYTES      = 2 * CHANNEL_COUNT;
    localparam int FRAME_BYTES = NBYTES + 2;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    logic                          busy_reg;
    logic [IDX_W-1:0]              idx_reg;
    work_t                         frame_reg;
    logic [FRAME_BYTES-1:0][7:0]   frame_bytes;
    logic                          at_last;
    logic                          load;

    assign at_last  = (idx_reg == LAST_IDX);
    assign in_ready = !busy_reg || (m_ready && at_last);
    assign load     = in_valid && in_ready;

    always_comb begin
        for (int i = 0; i < NBYTES; i++) begin
            frame_bytes[i] = frame_reg.bytes[i];
        end
        frame_bytes[NBYTES]     = frame_reg.crc[7:0];
        frame_bytes[NBYTES + 1] = frame_reg.crc[15:8];
    end

    assign m_valid           = busy_reg;
    assign m_item.frame_byte = frame_bytes[idx_reg];
    assign m_item.last_byte  = at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            if (at_last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= in_data;
        end
    end

    `SFCRC_ASSERT_NEXT(a_load_restarts, aclk, aresetn, load, busy_reg && idx_reg == '0, "frame did not restart at first byte")
    `SFCRC_ASSERT_NEXT(a_stall_index, aclk, aresetn, busy_reg && !m_ready, busy_reg && $stable(idx_reg), "byte index moved during stall")
    `SFCRC_ASSERT_IMPLY(a_index_range, aclk, aresetn, busy_reg, idx_reg <= LAST_IDX, "byte index beyond frame")

endmodule

/* sv/scope_frame_crc16_encoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_frame_crc16_encoder_core
// Scope frame encoder for one to four channels, four by default: sample bytes followed by CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_item takes one request of four 16-bit samples.
//   m_valid/m_ready/m_item returns the frame, one byte per request: each
//   channel low byte then high byte, then CRC low and CRC high byte; the
//   CRC high byte carries last_byte. Frame length is 2*channels + 2 bytes.
//   An input request passes through one CRC stage per sample byte, each
//   folding eight bits, and then the serializer register before its first
//   byte appears. Frame rate is set by the byte serializer, which holds
//   one frame at a time and sends its bytes in turn; the stage pipeline
//   takes a new request every cycle while it has room, and the next frame
//   is loaded as the last byte goes.
//   Reset clears every valid bit; nothing else needs clearing.
//   When m_ready is low, the current byte holds and the pipeline fills,
//   then s_ready drops; no request is lost or repeated.
// ----------------------------------------------------------------------------
module scope_frame_crc16_encoder_core #(
    parameter int CHANNEL_COUNT = sfcrc_pkg::CHANNEL_COUNT_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sfcrc_pkg::in_t  s_item,
    output logic            m_valid,
    input  logic            m_ready,
    output sfcrc_pkg::out_t m_item
);
    import sfcrc_pkg::*;

    localparam int CH_USED = (CHANNEL_COUNT < 1) ? 1 :
                             ((CHANNEL_COUNT > INPUT_FIELDS) ? INPUT_FIELDS : CHANNEL_COUNT);
    localparam int NBYTES  = 2 * CH_USED;

    work_t stage_data  [0:NBYTES];
    logic  stage_valid [0:NBYTES];
    logic  stage_ready [0:NBYTES];

    assign stage_data[0].bytes = to_bytes(s_item);
    assign stage_data[0].crc   = CRC_PRESET;
    assign stage_valid[0]      = s_valid;
    assign s_ready             = stage_ready[0];

    for (genvar k = 0; k < NBYTES; k++) begin : g_stage
        sfcrc_byte_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_data   (stage_data[k]),
            .in_byte   (stage_data[k].bytes[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    sfcrc_serializer #(
        .CHANNEL_COUNT (CH_USED)
    ) u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stage_valid[NBYTES]),
        .in_ready (stage_ready[NBYTES]),
        .in_data  (stage_data[NBYTES]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Scope frame encoder check: sets of four samples go in, and every byte of
// each 10-byte frame is compared with a local CRC-16/MODBUS frame builder.
// Both handshakes idle at random, and one long output hold-off backs the
// encoder up until its input stalls.
// ----------------------------------------------------------------------------
module testbench;
    import sfcrc_pkg::*;

    localparam int CHANNELS     = CHANNEL_COUNT_DEFAULT;
    // Framed channel count: at least one, at most the four input fields
    localparam int FRAMED       = (CHANNELS < 1) ? 1 :
                                  ((CHANNELS > INPUT_FIELDS) ? INPUT_FIELDS : CHANNELS);
    localparam int RANDOM_SETS  = 194;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_OFF_AT  = 200;
    localparam int HOLD_OFF_LEN = 150;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_item  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_item;

    in_t  sample_sets[$];
    out_t frame_bytes_due[$];

    int   errors       = 0;
    int   sets_sent    = 0;
    int   bytes_seen   = 0;
    int   cycle_count  = 0;
    int   tx_gap       = 0;
    int   tx_calm_left = 0;
    bit   tx_calm      = 1'b0;
    int   rx_stall     = 0;
    int   rx_calm_left = 0;
    bit   rx_calm      = 1'b0;
    int   rx_taken     = 0;
    bit   held_off     = 1'b0;

    scope_frame_crc16_encoder_core #(
        .CHANNEL_COUNT(CHANNELS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #1 aclk = ~aclk;

    // Reflected CRC-16, one bit at a time
    function automatic logic [15:0] modbus_crc_byte(logic [15:0] crc, logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        repeat (8) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void queue_frame_bytes(in_t set);
        logic [15:0] samples [INPUT_FIELDS];
        logic [15:0] crc;
        out_t        b;
        samples[0] = set.channel_0;
        samples[1] = set.channel_1;
        samples[2] = set.channel_2;
        samples[3] = set.channel_3;
        crc = 16'hFFFF;
        for (int ch = 0; ch < FRAMED; ch++) begin
            crc = modbus_crc_byte(crc, samples[ch][7:0]);
            crc = modbus_crc_byte(crc, samples[ch][15:8]);
            b.last_byte  = 1'b0;
            b.frame_byte = samples[ch][7:0];
            frame_bytes_due.push_back(b);
            b.frame_byte = samples[ch][15:8];
            frame_bytes_due.push_back(b);
        end
        b.frame_byte = crc[7:0];
        b.last_byte  = 1'b0;
        frame_bytes_due.push_back(b);
        b.frame_byte = crc[15:8];
        b.last_byte  = 1'b1;
        frame_bytes_due.push_back(b);
    endfunction

    // Mostly short gaps, the odd long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic in_t make_set(logic [15:0] a, logic [15:0] b,
                                     logic [15:0] c, logic [15:0] d);
        in_t s;
        s.channel_0 = a;
        s.channel_1 = b;
        s.channel_2 = c;
        s.channel_3 = d;
        return s;
    endfunction

    // Sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // request still pending, hold it
        end else if (tx_gap > 0) begin
            tx_gap--;
            s_valid <= 1'b0;
        end else if (sample_sets.size() > 0) begin
            s_valid <= 1'b1;
            s_item  <= sample_sets.pop_front();
            if (tx_calm_left == 0) begin
                tx_calm_left = $urandom_range(10, 40);
                tx_calm      = ($urandom_range(0, 2) == 0);
            end
            tx_calm_left--;
            tx_gap = tx_calm ? 0 : idle_len();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off to back the pipe up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) rx_taken++;
            if (!held_off && rx_taken >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                rx_stall = HOLD_OFF_LEN;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                if (rx_calm_left == 0) begin
                    rx_calm_left = $urandom_range(10, 60);
                    rx_calm      = ($urandom_range(0, 2) == 0);
                end
                rx_calm_left--;
                if (!rx_calm && $urandom_range(0, 99) < 20) begin
                    rx_stall = idle_len();
                    m_ready <= (rx_stall == 0);
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // Monitor: predict on input requests, compare on output requests
    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                queue_frame_bytes(s_item);
                sets_sent++;
            end
            if (m_valid && m_ready) begin
                bytes_seen++;
                if (frame_bytes_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected byte %02h last=%0b", $time,
                             m_item.frame_byte, m_item.last_byte);
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (m_item.frame_byte !== want.frame_byte) begin
                        errors++;
                        $display("%0t: frame_byte expected %02h, got %02h", $time,
                                 want.frame_byte, m_item.frame_byte);
                    end
                    if (m_item.last_byte !== want.last_byte) begin
                        errors++;
                        $display("%0t: last_byte expected %0b, got %0b", $time,
                                 want.last_byte, m_item.last_byte);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
                     frame_bytes_due.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        // directed: extremes, sign boundaries, byte patterns
        sample_sets.push_back(make_set(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        sample_sets.push_back(make_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        sample_sets.push_back(make_set(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        sample_sets.push_back(make_set(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        sample_sets.push_back(make_set(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF));
        sample_sets.push_back(make_set(16'h00FF, 16'hFF00, 16'h0001, 16'h0100));
        sample_sets.push_back(make_set(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        sample_sets.push_back(make_set(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
        // walking ones (channels 0, 1) and zeros (channels 2, 3): even bits on 0 and 2, odd bits on 1 and 3
        for (int i = 0; i < 16; i += 2) begin
            sample_sets.push_back(make_set(16'h0001 << i, 16'h0001 << (i + 1),
                                           ~(16'h0001 << i), ~(16'h0001 << (i + 1))));
        end
        for (int n = 0; n < RANDOM_SETS; n++) begin
            sample_sets.push_back(make_set(pick_sample(), pick_sample(),
                                           pick_sample(), pick_sample()));
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (sample_sets.size() != 0 || s_valid || frame_bytes_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("%0d sample sets framed, %0d frame bytes compared", sets_sent, bytes_seen);
        $display("random idling on both sides, long output hold-off %s",
                 held_off ? "applied" : "not reached");
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/sfcrc_pkg.sv
sv/sfcrc_byte_stage.sv
sv/sfcrc_serializer.sv
sv/scope_frame_crc16_encoder_core.sv
tb/testbench.sv
